// File: rtl/core/pq15_pkg.sv
// Package for the 15-bit palette quantizer: widths, storage words, control types
// and the channel conversion and color distance functions.
// No dependencies; every other file of the block imports it.
`default_nettype none

package pq15_pkg;

	// Field and storage widths.
	localparam int PAL_ENTRIES_DEF = 16;
	localparam int IDX_W           = 4;
	localparam int CH_W            = 5;
	localparam int KEY_W           = 3 * CH_W;
	localparam int COLOR_W         = 16;
	localparam int PIX_W           = 8;
	localparam int NF_W            = 5;
	localparam int THR_W           = 8;
	localparam int DIST_W          = 10;
	localparam int EPOCH_W         = 8;
	localparam int MAP_AW          = KEY_W;
	localparam int MAP_DEPTH       = 1 << MAP_AW;

	localparam logic [THR_W-1:0]  THR_RESET  = 8'd10;
	localparam logic [DIST_W-1:0] DIST_START = 10'd255;

	// One color map word: the image epoch it was written in, a valid flag and the index.
	typedef struct packed {
		logic [EPOCH_W-1:0] epoch;
		logic               valid;
		logic [IDX_W-1:0]   idx;
	} map_word_t;

	// Palette write request.
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   idx;
		logic [COLOR_W-1:0] color;
	} pal_wr_t;

	// Nearest entry found by the palette search.
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [IDX_W-1:0]  idx;
	} best_t;

	typedef enum logic [0:0] {
		ST_RUN,
		ST_SWEEP
	} ctl_state_t;

	// c*31/255, done as x - x/256 rounding: floor(x/255) = (x + x/256 + 1) / 256.
	function automatic logic [CH_W-1:0] narrow5(input logic [PIX_W-1:0] c);
		logic [12:0] x;
		logic [13:0] s;
		x = {c, 5'b0} - {5'b0, c};
		s = {1'b0, x} + {9'b0, x[12:8]} + 14'd1;
		return s[12:8];
	endfunction

	// v*255/31 = 8v + floor(7v/31); the division uses the reciprocal 265/8192.
	function automatic logic [PIX_W-1:0] widen8(input logic [CH_W-1:0] v);
		logic [7:0]  n;
		logic [15:0] m;
		n = {v, 3'b0} - {3'b0, v};
		m = {8'b0, n} * 16'd265;
		return {v, 3'b0} + {5'b0, m[15:13]};
	endfunction

	function automatic logic [PIX_W-1:0] absdiff8(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// Manhattan distance between two packed colors, on expanded channels.
	function automatic logic [DIST_W-1:0] color_distance(input logic [KEY_W-1:0] key,
		input logic [COLOR_W-1:0] col);
		logic [PIX_W-1:0] dr;
		logic [PIX_W-1:0] dg;
		logic [PIX_W-1:0] db;
		dr = absdiff8(widen8(key[4:0]), widen8(col[4:0]));
		dg = absdiff8(widen8(key[9:5]), widen8(col[9:5]));
		db = absdiff8(widen8(key[14:10]), widen8(col[14:10]));
		return {2'b0, dr} + {2'b0, dg} + {2'b0, db};
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/pq15_if.sv
// Channel interfaces of the 15-bit palette quantizer: the pixel stream in and
// the index stream out, each with valid and ready. Depends on pq15_pkg.
`default_nettype none

interface pq15_pixel_if;
	import pq15_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_in;
	logic [PIX_W-1:0] green_in;
	logic [PIX_W-1:0] blue_in;
	logic             is_transparent;
	logic             image_start;

	modport source (output valid, red_in, green_in, blue_in, is_transparent, image_start,
		input ready);
	modport sink (input valid, red_in, green_in, blue_in, is_transparent, image_start,
		output ready);
endinterface

interface pq15_result_if;
	import pq15_pkg::*;
	logic               valid;
	logic               ready;
	logic [IDX_W-1:0]   pixel_index;
	logic               entry_added;
	logic [COLOR_W-1:0] added_color;

	modport source (output valid, pixel_index, entry_added, added_color, input ready);
	modport sink (input valid, pixel_index, entry_added, added_color, output ready);
endinterface

`default_nettype wire

// File: rtl/core/palette_quantizer_15bit.sv
// Top level of the 15-bit palette quantizer: control, counters, color map
// and palette. Depends on pq15_pkg, pq15_if, pq15_color_map and pq15_palette.
//
// Usage:
//  - pixel carries one RGB888 pixel with its transparent and image start flags;
//    result returns one palette index per pixel, with the added color when the
//    pixel created a new palette entry. Both use valid/ready transfers.
//  - cfg_wr_en/cfg_wr_data write the match threshold; write it only while idle.
//  - A pixel is taken only after the last one left stage 1, for the color map
//    read-modify-write (read after the transfer, search, then write back).
//  - Map entries carry an 8-bit image epoch. After reset, and on every 256th
//    image start, a clearing pass writes all 32768 map words, one per cycle;
//    ready is low during the pass (the image start pixel waits inside).
//  - The result sits in an output register. While the receiver stalls, the
//    next pixel is still taken and waits in the search stage.
`default_nettype none

module palette_quantizer_15bit
	import pq15_pkg::*;
#(
	parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
)(
	input  wire logic             clk,
	input  wire logic             arst_n,
	pq15_pixel_if.sink            pixel,
	pq15_result_if.source         result,
	input  wire logic             cfg_wr_en,
	input  wire logic [THR_W-1:0] cfg_wr_data
);

	ctl_state_t          state_q, state_d;
	logic [MAP_AW-1:0]   sweep_addr_q;
	logic                sweep_last;
	logic                pend_q;
	logic [EPOCH_W-1:0]  epoch_q;
	logic [NF_W-1:0]     nf_q;
	logic [THR_W-1:0]    thr_q;

	logic                s1_valid_q;
	logic [KEY_W-1:0]    key_s1;
	logic                transp_s1;
	logic                start_s1;
	logic                fwd_s1;
	logic [IDX_W-1:0]    fwd_idx_s1;

	logic                s2_valid_q;
	logic [KEY_W-1:0]    key_s2;
	logic                transp_s2;
	logic                hit_s2;
	logic [IDX_W-1:0]    hit_idx_s2;

	logic                out_valid_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic                out_added_q;
	logic [COLOR_W-1:0]  out_color_q;

	logic                acc;
	logic                wrap;
	logic                s2_adv;
	logic [KEY_W-1:0]    key_in;
	logic                s1_launch;
	logic                hit_s1;
	logic [IDX_W-1:0]    hit_idx_s1;

	logic                dec_add;
	logic                dec_mwr;
	logic [IDX_W-1:0]    dec_idx;

	logic                rd_en;
	logic [MAP_AW-1:0]   rd_addr;
	map_word_t           rd_data;
	logic                wr_en;
	logic [MAP_AW-1:0]   wr_addr;
	map_word_t           wr_data;
	pal_wr_t             pal_wr;
	best_t               best;

	// Handshake and packing of the incoming pixel.
	assign key_in = {narrow5(pixel.blue_in), narrow5(pixel.green_in), narrow5(pixel.red_in)};
	assign s2_adv = s2_valid_q && (!out_valid_q || result.ready);
	assign pixel.ready = (state_q == ST_RUN) && !s1_valid_q && (!s2_valid_q || s2_adv);
	assign acc = pixel.valid && pixel.ready;
	assign wrap = acc && pixel.image_start && (epoch_q == '1);
	assign sweep_last = (sweep_addr_q == '1);

	// Sequencer: normal run, or the clearing pass over the color map.
	always_comb begin
		state_d   = state_q;
		s1_launch = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				if (wrap) begin
					state_d = ST_SWEEP;
				end else if (acc) begin
					s1_launch = 1'b1;
				end
			end
			ST_SWEEP: begin
				if (sweep_last) begin
					state_d   = ST_RUN;
					s1_launch = pend_q;
				end
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_addr_q <= '0;
			pend_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SWEEP) begin
				sweep_addr_q <= sweep_addr_q + 1'b1;
			end
			if (wrap) begin
				pend_q <= 1'b1;
			end else if (state_q == ST_SWEEP && sweep_last) begin
				pend_q <= 1'b0;
			end
		end
	end

	// Map read for a launched pixel; writes come from the sweep or the decision.
	assign rd_en   = s1_launch;
	assign rd_addr = (state_q == ST_SWEEP) ? key_s1 : key_in;
	assign wr_en   = (state_q == ST_SWEEP) || (s2_adv && dec_mwr);
	assign wr_addr = (state_q == ST_SWEEP) ? sweep_addr_q : key_s2;
	assign wr_data = (state_q == ST_SWEEP) ? map_word_t'('0) :
		map_word_t'{epoch: epoch_q, valid: 1'b1, idx: dec_idx};

	pq15_color_map u_map (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Image epoch, next free entry and the threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= '0;
			nf_q    <= '0;
			thr_q   <= THR_RESET;
		end else begin
			if (acc && pixel.image_start) begin
				epoch_q <= epoch_q + 1'b1;
				nf_q    <= {{(NF_W-1){1'b0}}, pixel.is_transparent};
			end else if (s2_adv && dec_add) begin
				nf_q <= nf_q + 1'b1;
			end
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
		end
	end

	// Stage 1: pixel held while the map is read. A write-back to the same color
	// in the transfer cycle is forwarded. A pixel that starts a new image always
	// misses, since its image begins with an empty map.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= s1_launch;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			key_s1     <= key_in;
			transp_s1  <= pixel.is_transparent;
			start_s1   <= pixel.image_start;
			fwd_s1     <= s2_adv && dec_mwr && (key_s2 == key_in) && !pixel.image_start;
			fwd_idx_s1 <= dec_idx;
		end
	end

	assign hit_s1     = !start_s1 &&
		(fwd_s1 || (rd_data.valid && (rd_data.epoch == epoch_q)));
	assign hit_idx_s1 = fwd_s1 ? fwd_idx_s1 : rd_data.idx;

	// Stage 2: lookup result and search distances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_valid_q) begin
			s2_valid_q <= 1'b1;
		end else if (s2_adv) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			key_s2     <= key_s1;
			transp_s2  <= transp_s1;
			hit_s2     <= hit_s1;
			hit_idx_s2 <= hit_idx_s1;
		end
	end

	assign pal_wr = '{en: s2_adv && dec_add, idx: nf_q[IDX_W-1:0], color: {1'b1, key_s2}};

	pq15_palette #(
		.ENTRIES (PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (acc && pixel.image_start),
		.wr      (pal_wr),
		.key     (key_s1),
		.dist_ld (s1_valid_q),
		.best    (best)
	);

	// Decision: transparent pixel, known color, reuse of the nearest entry, or a new entry.
	always_comb begin
		dec_add = 1'b0;
		dec_mwr = 1'b0;
		dec_idx = '0;
		priority if (transp_s2) begin
			dec_idx = '0;
		end else if (hit_s2) begin
			dec_idx = hit_idx_s2;
		end else if (best.distance < {2'b0, thr_q} && nf_q != '0) begin
			dec_idx = best.idx;
			dec_mwr = 1'b1;
		end else if (nf_q >= NF_W'(PALETTE_ENTRIES)) begin
			dec_idx = best.idx;
			dec_mwr = 1'b1;
		end else begin
			dec_idx = nf_q[IDX_W-1:0];
			dec_add = 1'b1;
			dec_mwr = 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_idx_q   <= dec_idx;
			out_added_q <= dec_add;
			out_color_q <= dec_add ? {1'b1, key_s2} : '0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.pixel_index = out_idx_q;
	assign result.entry_added = out_added_q;
	assign result.added_color = out_color_q;

endmodule

`default_nettype wire

// File: rtl/core/pq15_color_map.sv
// Color map memory: one word per 15-bit color, one write and one read port,
// read data registered. Depends on pq15_pkg.
`default_nettype none

module pq15_color_map
	import pq15_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [MAP_AW-1:0] rd_addr,
	output map_word_t              rd_data,
	input  wire logic              wr_en,
	input  wire logic [MAP_AW-1:0] wr_addr,
	input  wire map_word_t         wr_data
);

	map_word_t mem [MAP_DEPTH];

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/pq15_palette.sv
// Palette registers with the nearest-entry search: distances are registered,
// then reduced by a compare tree. Depends on pq15_pkg.
`default_nettype none

module pq15_palette
	import pq15_pkg::*;
#(
	parameter int ENTRIES = PAL_ENTRIES_DEF
)(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             clr,
	input  wire pal_wr_t          wr,
	input  wire logic [KEY_W-1:0] key,
	input  wire logic             dist_ld,
	output best_t                 best
);

	localparam int ENTRY_AW = $clog2(ENTRIES);
	localparam int LEVELS   = $clog2(ENTRIES);
	localparam int LEAVES   = 1 << LEVELS;

	logic [COLOR_W-1:0] pal_q [ENTRIES];
	logic [DIST_W-1:0]  dist_s2 [1:ENTRIES-1];
	best_t              node [LEVELS+1][LEAVES];

	// Palette storage; a clear for a new image wins over a write in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < ENTRIES; p++) begin
				pal_q[p] <= '0;
			end
		end else if (clr) begin
			for (int p = 0; p < ENTRIES; p++) begin
				pal_q[p] <= '0;
			end
		end else if (wr.en) begin
			pal_q[wr.idx[ENTRY_AW-1:0]] <= wr.color;
		end
	end

	// Distance of the key to every searched entry, one per lane.
	always_ff @(posedge clk) begin
		if (dist_ld) begin
			for (int p = 1; p < ENTRIES; p++) begin
				dist_s2[p] <= color_distance(key, pal_q[p]);
			end
		end
	end

	// Minimum tree. Leaf 0 stands for the start value, so a tie or nothing
	// below it keeps the lower index; unused leaves never win.
	always_comb begin
		for (int l = 0; l <= LEVELS; l++) begin
			for (int i = 0; i < LEAVES; i++) begin
				node[l][i] = '{distance: '1, idx: '0};
			end
		end
		node[0][0] = '{distance: DIST_START, idx: '0};
		for (int p = 1; p < ENTRIES; p++) begin
			node[0][p] = '{distance: dist_s2[p], idx: IDX_W'(p)};
		end
		for (int l = 0; l < LEVELS; l++) begin
			for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
				if (node[l][2*i].distance <= node[l][2*i+1].distance) begin
					node[l+1][i] = node[l][2*i];
				end else begin
					node[l+1][i] = node[l][2*i+1];
				end
			end
		end
		best = node[LEVELS][0];
	end

endmodule

`default_nettype wire

// File: verif/palette_quantizer_15bit_tb.sv
`timescale 1ns / 1ps
// Testbench for palette_quantizer_15bit: drives pixel transfers, predicts each palette
// index in a behavioral shadow of the block and checks every result transfer.
// Depends on pq15_pkg, the pq15 channel interfaces and the RTL of the block.

module palette_quantizer_15bit_tb;
	import pq15_pkg::*;

	typedef struct {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             transparent;
		logic             start;
	} rgb_pixel_t;

	typedef struct {
		logic [IDX_W-1:0]   pix_idx;
		logic               added;
		logic [COLOR_W-1:0] color;
	} index_result_t;

	localparam int PAL_SLOTS  = PAL_ENTRIES_DEF;
	localparam int STALL_LONG = 400;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [THR_W-1:0] cfg_wr_data;

	pq15_pixel_if  pixel_ch ();
	pq15_result_if result_ch ();

	palette_quantizer_15bit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel       (pixel_ch),
		.result      (result_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Shadow state of the quantizer.
	logic [COLOR_W-1:0] pal_shadow [PAL_SLOTS];
	logic [IDX_W-1:0]   idx_of_color [int];
	logic [NF_W-1:0]    free_slot;
	logic [THR_W-1:0]   thr_shadow;

	index_result_t predicted_indexes [$];
	int fail_count = 0;
	int src_gap_pct = 0;
	int sink_stall_pct = 0;
	int stall_left = 0;
	logic stall_request = 1'b0;
	logic stall_taken = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int narrow_channel(input logic [PIX_W-1:0] c);
		return (int'(c) * 31) / 255;
	endfunction

	function automatic int widen_channel(input logic [CH_W-1:0] v);
		return (int'(v) * 255) / 31;
	endfunction

	// Manhattan distance on channels expanded back to 8 bits.
	function automatic int color_gap(input logic [COLOR_W-1:0] a, input logic [COLOR_W-1:0] b);
		int d;
		int ca;
		int cb;
		d = 0;
		for (int sh = 0; sh < KEY_W; sh += CH_W) begin
			ca = widen_channel(a[sh +: CH_W]);
			cb = widen_channel(b[sh +: CH_W]);
			d += (ca > cb) ? ca - cb : cb - ca;
		end
		return d;
	endfunction

	// Works out the index for one accepted pixel and updates the shadow state.
	function automatic index_result_t assign_palette_index(input rgb_pixel_t px);
		index_result_t r;
		logic [COLOR_W-1:0] key;
		int best;
		int best_p;
		int d;
		r = '{pix_idx: '0, added: 1'b0, color: '0};
		if (px.start) begin
			idx_of_color.delete();
			foreach (pal_shadow[i])
				pal_shadow[i] = '0;
			free_slot = {4'b0, px.transparent};
		end
		key = {1'b1, CH_W'(narrow_channel(px.blue)), CH_W'(narrow_channel(px.green)),
			CH_W'(narrow_channel(px.red))};
		if (!px.transparent) begin
			if (idx_of_color.exists(int'(key[KEY_W-1:0]))) begin
				r.pix_idx = idx_of_color[int'(key[KEY_W-1:0])];
			end else begin
				best = 255;
				best_p = 0;
				for (int p = 1; p < PAL_SLOTS; p++) begin
					d = color_gap(key, pal_shadow[p]);
					if (d < best) begin
						best = d;
						best_p = p;
					end
				end
				if (best < int'(thr_shadow) && free_slot != 0) begin
					r.pix_idx = IDX_W'(best_p);
				end else if (free_slot >= PAL_SLOTS) begin
					r.pix_idx = IDX_W'(best_p);
				end else begin
					r.pix_idx = free_slot[IDX_W-1:0];
					pal_shadow[free_slot[IDX_W-1:0]] = key;
					free_slot = free_slot + 1'b1;
					r.added = 1'b1;
					r.color = key;
				end
				idx_of_color[int'(key[KEY_W-1:0])] = r.pix_idx;
			end
		end
		return r;
	endfunction

	function automatic rgb_pixel_t make_pixel(input int r, input int g, input int b,
		input logic transparent, input logic start);
		rgb_pixel_t px;
		px.red = PIX_W'(r);
		px.green = PIX_W'(g);
		px.blue = PIX_W'(b);
		px.transparent = transparent;
		px.start = start;
		return px;
	endfunction

	// Moves a channel by a small random amount, clamped to the 8-bit range.
	function automatic logic [PIX_W-1:0] nudge(input logic [PIX_W-1:0] c);
		int v;
		v = int'(c) + int'($urandom_range(0, 24)) - 12;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return PIX_W'(v);
	endfunction

	// Offers one pixel after random gaps and records its prediction once the transfer happens.
	task automatic send_pixel(input rgb_pixel_t px);
		while ($urandom_range(0, 99) < src_gap_pct) begin
			pixel_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pixel_ch.valid <= 1'b1;
		pixel_ch.red_in <= px.red;
		pixel_ch.green_in <= px.green;
		pixel_ch.blue_in <= px.blue;
		pixel_ch.is_transparent <= px.transparent;
		pixel_ch.image_start <= px.start;
		do
			@(posedge clk);
		while (!pixel_ch.ready);
		predicted_indexes.push_back(assign_palette_index(px));
	endtask

	// Stops offering pixels and waits until every predicted result has arrived.
	task automatic drain_results();
		pixel_ch.valid <= 1'b0;
		while (predicted_indexes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		thr_shadow = value;
	endtask

	// Random images: each draws most pixels from a small set of base colors with jitter.
	task automatic run_images(input int n_items);
		rgb_pixel_t base [$];
		rgb_pixel_t px;
		int sent;
		int len;
		int sel;
		sent = 0;
		while (sent < n_items) begin
			base.delete();
			repeat ($urandom_range(1, 24))
				base.push_back(make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 255), 1'b0, 1'b0));
			len = $urandom_range(8, 80);
			for (int j = 0; j < len; j++) begin
				sel = $urandom_range(0, 99);
				if (sel < 8) begin
					px = make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), 1'($urandom_range(0, 1)), 1'b0);
				end else if (sel < 18) begin
					px = make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), 1'b1, 1'b0);
				end else begin
					px = base[$urandom_range(0, base.size() - 1)];
					px.red = nudge(px.red);
					px.green = nudge(px.green);
					px.blue = nudge(px.blue);
				end
				// A stray image start now and then breaks an image in the middle.
				px.start = (j == 0) || ($urandom_range(0, 99) < 2);
				if (j == 0 && $urandom_range(0, 3) == 0)
					px.transparent = 1'b1;
				send_pixel(px);
			end
			sent += len;
		end
	endtask

	// Pixels right after reset, without an image start, then the special cases by hand.
	task automatic test_directed();
		send_pixel(make_pixel(0, 0, 0, 1'b0, 1'b0));
		send_pixel(make_pixel(255, 255, 255, 1'b0, 1'b0));
		send_pixel(make_pixel(255, 255, 255, 1'b0, 1'b0));
		send_pixel(make_pixel(247, 255, 255, 1'b0, 1'b0));
		send_pixel(make_pixel(255, 0, 255, 1'b1, 1'b0));
		send_pixel(make_pixel(8, 0, 0, 1'b0, 1'b0));
		// Transparent image start puts the counter at one; black then matches an empty entry.
		send_pixel(make_pixel(0, 0, 0, 1'b1, 1'b1));
		send_pixel(make_pixel(0, 0, 0, 1'b0, 1'b0));
		// Visible image start: the first new color lands in entry zero.
		send_pixel(make_pixel(128, 64, 200, 1'b0, 1'b1));
		// Far apart colors fill the palette, the last one finds it full.
		for (int k = 1; k <= 16; k++)
			send_pixel(make_pixel((k & 3) * 85, ((k >> 2) & 3) * 85, k * 15, 1'b0, 1'b0));
	endtask

	// The receiver holds off while pixels keep coming, then the sender waits for all results.
	task automatic test_backpressure();
		stall_request = 1'b1;
		repeat (30)
			send_pixel(make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), 1'($urandom_range(0, 1)), 1'b0));
		drain_results();
	endtask

	task automatic test_threshold_zero();
		write_threshold(8'd0);
		run_images(600);
		drain_results();
	endtask

	task automatic test_threshold_max();
		write_threshold(8'd255);
		run_images(600);
		drain_results();
	endtask

	task automatic test_threshold_random();
		write_threshold(THR_W'($urandom_range(1, 254)));
		run_images(400);
		drain_results();
		write_threshold(THR_W'($urandom_range(1, 254)));
		run_images(400);
		drain_results();
	endtask

	// Receiver ready, with random stalls and one long hold-off on request.
	always @(posedge clk) begin
		if (stall_request && !stall_taken) begin
			stall_left = STALL_LONG;
			stall_taken = 1'b1;
		end
		if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Each result transfer is compared with the oldest prediction.
	always @(posedge clk) begin : check_result
		index_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (predicted_indexes.size() == 0) begin
				$error("result transfer with no pixel pending: pixel_index %0d",
					result_ch.pixel_index);
				fail_count++;
			end else begin
				want = predicted_indexes.pop_front();
				if (result_ch.pixel_index !== want.pix_idx) begin
					$error("pixel_index: expected %0d, actual %0d", want.pix_idx,
						result_ch.pixel_index);
					fail_count++;
				end
				if (result_ch.entry_added !== want.added) begin
					$error("entry_added: expected %0d, actual %0d", want.added,
						result_ch.entry_added);
					fail_count++;
				end
				if (result_ch.added_color !== want.color) begin
					$error("added_color: expected %h, actual %h", want.color,
						result_ch.added_color);
					fail_count++;
				end
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		pixel_ch.valid <= 1'b0;
		pixel_ch.red_in <= '0;
		pixel_ch.green_in <= '0;
		pixel_ch.blue_in <= '0;
		pixel_ch.is_transparent <= 1'b0;
		pixel_ch.image_start <= 1'b0;
		foreach (pal_shadow[i])
			pal_shadow[i] = '0;
		free_slot = '0;
		thr_shadow = THR_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_gap_pct = 10;
		sink_stall_pct = 76;
		test_directed();
		drain_results();
		test_backpressure();
		test_threshold_zero();

		src_gap_pct = 76;
		sink_stall_pct = 10;
		test_threshold_max();

		src_gap_pct = 0;
		sink_stall_pct = 0;
		test_threshold_random();

		repeat (10) @(posedge clk);
		if (fail_count == 0 && predicted_indexes.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Run limit, far above the slowest correct run including the clearing pass after reset.
	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

endmodule
